// ----- rtl/assert_macros.svh -----
// Assertion macros shared by the RTL of the edge capture FIFO.
// Every macro samples on i_clk and is disabled while i_rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) \
        else $error(msg);

// Antecedent at one edge implies consequent at the next edge
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

// ----- rtl/tsecf_pkg.sv -----
// Package for the timestamped edge capture FIFO: default sizes, field widths
// and operation codes. No dependencies.
`timescale 1ns / 1ps

package tsecf_pkg;

    // default sizing, handed to the top level parameters
    localparam int DEPTH_DEF     = 64;
    localparam int TIME_BITS_DEF = 32;

    // fixed field widths of the command and result ports
    localparam int OP_W     = 1;
    localparam int LEVEL_W  = 1;
    localparam int STAMP_W  = 32;

    // operation codes
    localparam logic [OP_W-1:0] OP_TICK = 1'b0;
    localparam logic [OP_W-1:0] OP_READ = 1'b1;

endpackage

// ----- rtl/tsecf_ram.sv -----
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
`timescale 1ns / 1ps

module tsecf_ram #(
    parameter int WIDTH  = 33,
    parameter int DEPTH  = 64,
    parameter int ADDR_W = 6
) (
    input  logic              i_clk,
    input  logic              i_wr_en,
    input  logic [ADDR_W-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]  i_wr_data,
    input  logic              i_rd_en,
    input  logic [ADDR_W-1:0] i_rd_addr,
    output logic [WIDTH-1:0]  o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // registered read port, holds data between reads
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ----- rtl/timestamped_edge_capture_fifo.sv -----
// Top level of the timestamped edge capture FIFO: edge detection, ring pointers
// and result register. Depends on tsecf_pkg, tsecf_ram and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

// Usage
//   Command channel: a transfer happens at a rising edge with start high and
//   busy low. busy stays low, so a command is taken in every cycle.
//   i_op = tick: i_pin_level and i_sample_time are sampled. The first tick
//   after reset and every later change of level are stored as (time, level)
//   in a ring of DEPTH entries; when the ring is full the entry is dropped,
//   but the level still becomes the reference for the next edge.
//   i_op = read: pops the oldest entry. In the cycle after the command, o_valid
//   is high for exactly one cycle with o_found, o_event_time, o_event_level;
//   an empty ring gives o_found = 0 with zero time and level.
//   The read result comes from the registered read port of the entry memory.
//   Throughput: one command per cycle. Ticks give no result.
//   Reset (synchronous, i_rst_n low) empties the ring and forgets the last
//   level; the memory content is not cleared. The receiver cannot stall:
//   each result must be taken in the cycle o_valid is high.
module timestamped_edge_capture_fifo #(
    parameter int DEPTH     = tsecf_pkg::DEPTH_DEF,
    parameter int TIME_BITS = tsecf_pkg::TIME_BITS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           start,
    output logic                           busy,
    input  logic [tsecf_pkg::OP_W-1:0]     i_op,
    input  logic [tsecf_pkg::LEVEL_W-1:0]  i_pin_level,
    input  logic [tsecf_pkg::STAMP_W-1:0]  i_sample_time,
    output logic                           o_valid,
    output logic                           o_found,
    output logic [tsecf_pkg::STAMP_W-1:0]  o_event_time,
    output logic [tsecf_pkg::LEVEL_W-1:0]  o_event_level
);
    import tsecf_pkg::*;

    // stored stamp keeps only the bits that survive both masks
    localparam int ST_W   = (TIME_BITS < STAMP_W) ? TIME_BITS : STAMP_W;
    localparam int ENT_W  = ST_W + LEVEL_W;
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam logic [ADDR_W-1:0] LAST_IDX = ADDR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0]  FULL_CNT = CNT_W'(DEPTH);

    logic                r_level_known, n_level_known;
    logic [LEVEL_W-1:0]  r_last_level, n_last_level;
    logic [ADDR_W-1:0]   r_wr_idx, n_wr_idx;
    logic [ADDR_W-1:0]   r_rd_idx, n_rd_idx;
    logic [CNT_W-1:0]    r_fill, n_fill;
    logic                r_valid, n_valid;
    logic                r_found, n_found;

    logic                accept;
    logic                is_read;
    logic                record;
    logic                push;
    logic                pop;
    logic [ENT_W-1:0]    wr_entry;
    logic [ENT_W-1:0]    rd_entry;

    // commands are taken every cycle
    assign busy    = 1'b0;
    assign accept  = start && !busy;
    assign is_read = (i_op == OP_READ);

    // record the first tick and every change of level; drop when full
    assign record = accept && !is_read &&
                    (!r_level_known || (i_pin_level != r_last_level));
    assign push   = record && (r_fill != FULL_CNT);
    assign pop    = accept && is_read && (r_fill != '0);

    assign wr_entry = {ST_W'(i_sample_time), i_pin_level};

    // next state of pointers, count and edge reference
    always_comb begin
        n_level_known = r_level_known;
        n_last_level  = r_last_level;
        n_wr_idx      = r_wr_idx;
        n_rd_idx      = r_rd_idx;
        n_fill        = r_fill;
        if (record) begin
            n_level_known = 1'b1;
            n_last_level  = i_pin_level;
        end
        if (push) begin
            n_wr_idx = (r_wr_idx == LAST_IDX) ? '0 : r_wr_idx + 1'b1;
            n_fill   = r_fill + 1'b1;
        end
        if (pop) begin
            n_rd_idx = (r_rd_idx == LAST_IDX) ? '0 : r_rd_idx + 1'b1;
            n_fill   = r_fill - 1'b1;
        end
        n_valid = accept && is_read;
        n_found = pop;
    end

    // advance control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_level_known <= 1'b0;
            r_last_level  <= '0;
            r_wr_idx      <= '0;
            r_rd_idx      <= '0;
            r_fill        <= '0;
            r_valid       <= 1'b0;
            r_found       <= 1'b0;
        end else begin
            r_level_known <= n_level_known;
            r_last_level  <= n_last_level;
            r_wr_idx      <= n_wr_idx;
            r_rd_idx      <= n_rd_idx;
            r_fill        <= n_fill;
            r_valid       <= n_valid;
            r_found       <= n_found;
        end
    end

    // entry store
    tsecf_ram #(
        .WIDTH  (ENT_W),
        .DEPTH  (DEPTH),
        .ADDR_W (ADDR_W)
    ) u_store (
        .i_clk     (i_clk),
        .i_wr_en   (push),
        .i_wr_addr (r_wr_idx),
        .i_wr_data (wr_entry),
        .i_rd_en   (pop),
        .i_rd_addr (r_rd_idx),
        .o_rd_data (rd_entry)
    );

    // present the result, zeroed on an empty read
    assign o_valid       = r_valid;
    assign o_found       = r_found;
    assign o_event_time  = r_found ? STAMP_W'(rd_entry[ENT_W-1:LEVEL_W]) : '0;
    assign o_event_level = r_found ? rd_entry[LEVEL_W-1:0] : '0;

    // checks
    `ASSERT_CLK(a_fill_bound, r_fill <= FULL_CNT, "fill count above depth")
    `ASSERT_NEXT(a_read_result, accept && is_read, o_valid,
                 "read transfer without a result strobe")
    `ASSERT_NEXT(a_empty_read, accept && is_read && (r_fill == '0), !o_found,
                 "entry returned from an empty ring")
    `ASSERT_NEXT(a_idle_hold, !accept, $stable(r_fill) && !o_valid,
                 "state moved without a transfer")

endmodule

// ----- verif/edge_fifo_checker.sv -----
// Checker for the timestamped edge capture FIFO: watches the command and result
// ports, predicts every read result and compares. Depends on tsecf_pkg.
`timescale 1ns / 1ps

module edge_fifo_checker (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_start,
    input  logic                           i_busy,
    input  logic [tsecf_pkg::OP_W-1:0]     i_op,
    input  logic [tsecf_pkg::LEVEL_W-1:0]  i_pin_level,
    input  logic [tsecf_pkg::STAMP_W-1:0]  i_sample_time,
    input  logic                           i_valid,
    input  logic                           i_found,
    input  logic [tsecf_pkg::STAMP_W-1:0]  i_event_time,
    input  logic [tsecf_pkg::LEVEL_W-1:0]  i_event_level,
    output int                             o_outstanding,
    output int                             o_fail_count
);
    import tsecf_pkg::*;

    localparam int RING_DEPTH  = DEPTH_DEF;
    localparam int REPORT_MAX  = 30;

    typedef struct packed {
        logic               found;
        logic [STAMP_W-1:0] stamp;
        logic [LEVEL_W-1:0] level;
    } t_read_result;

    // model of the block: last level seen and the ring of recorded edges
    logic               seen_first;
    logic [LEVEL_W-1:0] ref_level;
    logic [STAMP_W-1:0] ring_stamp [RING_DEPTH];
    logic [LEVEL_W-1:0] ring_level [RING_DEPTH];
    int                 wr_ptr;
    int                 rd_ptr;
    int                 ring_fill;

    t_read_result       pending_reads [$];
    int                 fail_count;
    int                 reports;

    initial begin
        o_outstanding = 0;
        o_fail_count  = 0;
        fail_count    = 0;
        reports       = 0;
    end

    // advance the model by one accepted command; a read queues its result
    function automatic void apply_command(input logic [OP_W-1:0] op,
                                          input logic [LEVEL_W-1:0] lvl,
                                          input logic [STAMP_W-1:0] stamp);
        t_read_result res;
        if (op == OP_TICK) begin
            if (!seen_first || lvl != ref_level) begin
                seen_first = 1'b1;
                ref_level  = lvl;
                // drop the edge when the ring is full, keep the level
                if (ring_fill < RING_DEPTH) begin
                    ring_stamp[wr_ptr] = stamp;
                    ring_level[wr_ptr] = lvl;
                    wr_ptr    = (wr_ptr + 1) % RING_DEPTH;
                    ring_fill = ring_fill + 1;
                end
            end
        end else begin
            if (ring_fill == 0) begin
                res = '0;
            end else begin
                res.found = 1'b1;
                res.stamp = ring_stamp[rd_ptr];
                res.level = ring_level[rd_ptr];
                rd_ptr    = (rd_ptr + 1) % RING_DEPTH;
                ring_fill = ring_fill - 1;
            end
            pending_reads.push_back(res);
        end
    endfunction

    always @(posedge i_clk) begin
        t_read_result want;
        t_read_result got;
        if (!i_rst_n) begin
            seen_first = 1'b0;
            ref_level  = '0;
            wr_ptr     = 0;
            rd_ptr     = 0;
            ring_fill  = 0;
            pending_reads.delete();
        end else begin
            // compare a result transfer with the oldest outstanding read
            if (i_valid) begin
                got = '{found: i_found, stamp: i_event_time, level: i_event_level};
                if (pending_reads.size() == 0) begin
                    fail_count++;
                    if (reports < REPORT_MAX)
                        $display("%0t: unexpected result found=%0b time=%h level=%0b",
                                 $time, got.found, got.stamp, got.level);
                    reports++;
                end else begin
                    want = pending_reads[0];
                    pending_reads.delete(0);
                    if (got !== want) begin
                        fail_count++;
                        if (reports < REPORT_MAX)
                            $display({"%0t: result mismatch: expected found=%0b ",
                                      "time=%h level=%0b, got found=%0b time=%h level=%0b"},
                                     $time, want.found, want.stamp, want.level,
                                     got.found, got.stamp, got.level);
                        reports++;
                    end
                end
            end
            // take the command transfer into the model
            if (i_start && !i_busy)
                apply_command(i_op, i_pin_level, i_sample_time);
        end
        o_outstanding <= pending_reads.size();
        o_fail_count  <= fail_count;
    end

endmodule

// ----- verif/tb_top.sv -----
// Testbench top for the timestamped edge capture FIFO: clock, reset, command
// stimulus and verdict. Depends on tsecf_pkg, the block and edge_fifo_checker.
`timescale 1ns / 1ps

module tb_top;
    import tsecf_pkg::*;

    localparam int RANDOM_ITEMS = 1400;
    localparam int STALL_LIMIT  = 2000;
    localparam int SETTLE_CYCLES = 4;

    logic               i_clk         = 1'b0;
    logic               i_rst_n       = 1'b0;
    logic               start         = 1'b0;
    logic [OP_W-1:0]    i_op          = OP_TICK;
    logic [LEVEL_W-1:0] i_pin_level   = '0;
    logic [STAMP_W-1:0] i_sample_time = '0;
    logic               busy;
    logic               o_valid;
    logic               o_found;
    logic [STAMP_W-1:0] o_event_time;
    logic [LEVEL_W-1:0] o_event_level;

    int                 outstanding;
    int                 fail_count;
    int                 idle_pct;
    int                 sent;
    int                 quiet_cycles;
    logic [STAMP_W-1:0] stamp_now;
    logic [LEVEL_W-1:0] drive_level;

    timestamped_edge_capture_fifo i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .start         (start),
        .busy          (busy),
        .i_op          (i_op),
        .i_pin_level   (i_pin_level),
        .i_sample_time (i_sample_time),
        .o_valid       (o_valid),
        .o_found       (o_found),
        .o_event_time  (o_event_time),
        .o_event_level (o_event_level)
    );

    edge_fifo_checker i_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_start       (start),
        .i_busy        (busy),
        .i_op          (i_op),
        .i_pin_level   (i_pin_level),
        .i_sample_time (i_sample_time),
        .i_valid       (o_valid),
        .i_found       (o_found),
        .i_event_time  (o_event_time),
        .i_event_level (o_event_level),
        .o_outstanding (outstanding),
        .o_fail_count  (fail_count)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // end the run when neither a command nor a result moves for too long
    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_valid) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("timestamped_edge_capture_fifo verification failed");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // advance the running timestamp, now and then jump anywhere
    function automatic logic [STAMP_W-1:0] next_stamp();
        if ($urandom_range(0, 7) == 0)
            stamp_now = $urandom();
        else
            stamp_now = stamp_now + $urandom_range(1, 4096);
        return stamp_now;
    endfunction

    // hold off at random, then present one command until it is taken
    task automatic send_cmd(input logic [OP_W-1:0] op, input logic [LEVEL_W-1:0] lvl,
                            input logic [STAMP_W-1:0] stamp);
        while ($urandom_range(0, 99) < idle_pct) begin
            start         <= 1'b0;
            i_op          <= OP_W'($urandom());
            i_pin_level   <= LEVEL_W'($urandom());
            i_sample_time <= $urandom();
            @(posedge i_clk);
        end
        start         <= 1'b1;
        i_op          <= op;
        i_pin_level   <= lvl;
        i_sample_time <= stamp;
        do @(posedge i_clk); while (busy);
        sent++;
    endtask

    // drop start and wait until every read result has come back
    task automatic drain_results();
        start <= 1'b0;
        do @(posedge i_clk); while (outstanding != 0);
    endtask

    // one burst: a run of edges that may overflow the ring, a run of reads that
    // may empty it, or a random mix
    task automatic run_burst();
        int kind;
        int n;
        kind = $urandom_range(0, 9);
        if (kind < 3) begin
            n = $urandom_range(60, 80);
            repeat (n) begin
                if ($urandom_range(0, 4) != 0)
                    drive_level = ~drive_level;
                send_cmd(OP_TICK, drive_level, next_stamp());
            end
        end else if (kind < 6) begin
            n = $urandom_range(1, 72);
            repeat (n) send_cmd(OP_READ, LEVEL_W'($urandom()), $urandom());
        end else begin
            n = $urandom_range(1, 40);
            repeat (n) begin
                if ($urandom_range(0, 1) == 0) begin
                    drive_level = LEVEL_W'($urandom());
                    send_cmd(OP_TICK, drive_level, next_stamp());
                end else begin
                    send_cmd(OP_READ, LEVEL_W'($urandom()), $urandom());
                end
            end
        end
    endtask

    initial begin
        quiet_cycles = 0;
        sent         = 0;
        idle_pct     = 0;
        stamp_now    = '0;
        drive_level  = '0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: empty read, first tick at the reset level, repeated level,
        // extreme stamps, ignored fields on reads
        send_cmd(OP_READ, 1'b0, 32'h0000_0000);
        send_cmd(OP_TICK, 1'b0, 32'h0000_0000);
        send_cmd(OP_TICK, 1'b0, 32'h0000_0005);
        send_cmd(OP_TICK, 1'b1, 32'hFFFF_FFFF);
        send_cmd(OP_TICK, 1'b1, 32'h0000_0007);
        send_cmd(OP_TICK, 1'b0, 32'hAAAA_AAAA);
        send_cmd(OP_TICK, 1'b1, 32'h5555_5555);
        send_cmd(OP_READ, 1'b1, 32'hFFFF_FFFF);
        send_cmd(OP_READ, 1'b0, 32'h0000_0000);
        send_cmd(OP_READ, 1'b1, 32'h1234_5678);
        send_cmd(OP_READ, 1'b0, 32'hFFFF_FFFF);
        send_cmd(OP_READ, 1'b1, 32'h0000_0001);
        send_cmd(OP_TICK, 1'b1, 32'h0000_0001);
        send_cmd(OP_TICK, 1'b0, 32'h8000_0000);
        send_cmd(OP_READ, 1'b0, 32'h0000_0000);
        send_cmd(OP_TICK, 1'b1, 32'h7FFF_FFFF);
        send_cmd(OP_READ, 1'b0, 32'h0000_0000);
        send_cmd(OP_READ, 1'b0, 32'h0000_0000);
        drain_results();
        drive_level = 1'b1;

        // random: sender idles rarely, then often, then never; drain in between
        sent = 0;
        for (int phase = 0; phase < 3; phase++) begin
            idle_pct = (phase == 0) ? 20 : (phase == 1) ? 68 : 0;
            while (sent < (phase + 1) * RANDOM_ITEMS / 3)
                run_burst();
            drain_results();
        end

        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (fail_count == 0 && outstanding == 0)
            $display("timestamped_edge_capture_fifo verification clean");
        else
            $display("timestamped_edge_capture_fifo verification failed");
        $finish;
    end

endmodule
